// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define SDSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked on every rising edge outside reset.
`define SDSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define SDSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SDSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/sdsf_pkg.sv
// ----------------------------------------------------------------------------
// sdsf_pkg
// Field widths, segment tables and shared types of the segment formatter.
// ----------------------------------------------------------------------------
package sdsf_pkg;

  localparam int VALUE_W   = 25;
  localparam int DPOS_W    = 3;
  localparam int PATTERN_W = 16;
  localparam int DIGIT_W   = 4;

  // Wide enough for the signed display bounds at ten digits.
  localparam int BND_W     = 36;

  // Divide by ten: q = (x * RECIP) >> RECIP_SH is exact for any x below 2**32.
  localparam int           RECIP_W  = 32;
  localparam logic [31:0]  RECIP    = 32'hCCCC_CCCD;
  localparam int           RECIP_SH = 35;

  localparam logic [PATTERN_W-1:0] MINUS_PATTERN = 16'h0040;

  typedef struct packed {
    logic [DPOS_W-1:0]    digit_pos;
    logic [PATTERN_W-1:0] pattern;
    logic                 digit_valid;
    logic                 sign_write;
    logic                 sign_negative;
    logic                 error;
    logic                 last;
  } res_t;

  // Used only to size the range bounds at elaboration.
  function automatic longint pow10(input int n);
    longint r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  function automatic logic [PATTERN_W-1:0] seg7_pattern(input logic [DIGIT_W-1:0] d);
    logic [PATTERN_W-1:0] p;
    unique case (d)
      4'd0:    p = 16'h003F;
      4'd1:    p = 16'h0006;
      4'd2:    p = 16'h005B;
      4'd3:    p = 16'h004F;
      4'd4:    p = 16'h0066;
      4'd5:    p = 16'h006D;
      4'd6:    p = 16'h007D;
      4'd7:    p = 16'h0007;
      4'd8:    p = 16'h007F;
      4'd9:    p = 16'h006F;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [PATTERN_W-1:0] alnum_pattern(input logic [DIGIT_W-1:0] d);
    logic [PATTERN_W-1:0] p;
    unique case (d)
      4'd0:    p = 16'h003F;
      4'd1:    p = 16'h0006;
      4'd2:    p = 16'h045B;
      4'd3:    p = 16'h044F;
      4'd4:    p = 16'h0466;
      4'd5:    p = 16'h046D;
      4'd6:    p = 16'h047D;
      4'd7:    p = 16'h0007;
      4'd8:    p = 16'h047F;
      4'd9:    p = 16'h046F;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// File: src/sdsf_in_if.sv
// ----------------------------------------------------------------------------
// sdsf_in_if
// Input channel: a signed value and the display it is meant for.
// ----------------------------------------------------------------------------
interface sdsf_in_if import sdsf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      target_large;

  modport source (output valid, output value, output target_large, input ready);
  modport sink   (input valid, input value, input target_large, output ready);
endinterface

// File: src/sdsf_out_if.sv
// ----------------------------------------------------------------------------
// sdsf_out_if
// Result channel: one digit write, sign update or error per item.
// ----------------------------------------------------------------------------
interface sdsf_out_if import sdsf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DPOS_W-1:0]    digit_pos;
  logic [PATTERN_W-1:0] pattern;
  logic                 digit_valid;
  logic                 sign_write;
  logic                 sign_negative;
  logic                 error;
  logic                 last;

  modport source (output valid, output digit_pos, output pattern, output digit_valid,
                  output sign_write, output sign_negative, output error, output last,
                  input ready);
  modport sink   (input valid, input digit_pos, input pattern, input digit_valid,
                  input sign_write, input sign_negative, input error, input last,
                  output ready);
endinterface

// File: src/signed_decimal_segment_formatter_core.sv
// ----------------------------------------------------------------------------
// signed_decimal_segment_formatter_core
// Turns a signed integer into per-digit segment writes for a small numeric
// or a large alphanumeric display, blanking leading positions.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Payload                                         Per item
//   in_chan   in    value[24:0] signed, target_large                 one number
//   out_chan  out   digit_pos, pattern, digit_valid, sign_write,     one write
//                   sign_negative, error, last
//
// An item is taken in idle and range-checked in the check state, which also
// writes the minus glyph of a negative number on the small display; then one
// digit or blank is written per position, from the top position of the chosen
// display down to 0, or to 1 for a negative value. An out-of-range item ends
// with a single error write. The rate is set by the single divide-by-ten
// unit, which yields one digit per cycle while the output register can take
// it. Reset is synchronous and clears the sequencer and the output valid
// flag only. A stalled result holds in the output register and the
// sequencer waits on it; in_chan.ready is high whenever the sequencer is idle.
`include "assert_macros.svh"

module signed_decimal_segment_formatter_core import sdsf_pkg::*; #(
  parameter int SMALL_DIGITS = 4,
  parameter int LARGE_DIGITS = 7
) (
  input logic        clk,
  input logic        rst_n,
  sdsf_in_if.sink    in_chan,
  sdsf_out_if.source out_chan
);

  // Digit positions count down from ndig-1; they need only index the larger
  // display. The result field carries the low three bits.
  localparam int MAX_DIG = (SMALL_DIGITS > LARGE_DIGITS) ? SMALL_DIGITS : LARGE_DIGITS;
  localparam int POS_W   = $clog2(MAX_DIG);
  localparam int MAG_W   = VALUE_W;
  localparam int PROD_W  = MAG_W + RECIP_W;

  // Accepted range of each display: -(10^(n-1)-1) .. 10^n-1.
  localparam logic signed [BND_W-1:0] S_HI = BND_W'(pow10(SMALL_DIGITS) - 64'sd1);
  localparam logic signed [BND_W-1:0] S_LO = BND_W'(64'sd1 - pow10(SMALL_DIGITS - 1));
  localparam logic signed [BND_W-1:0] L_HI = BND_W'(pow10(LARGE_DIGITS) - 64'sd1);
  localparam logic signed [BND_W-1:0] L_LO = BND_W'(64'sd1 - pow10(LARGE_DIGITS - 1));

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIGIT = 2'd2;
  localparam logic [1:0] ST_BLANK = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic                    large_r, large_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic                    sign_pend_r, sign_pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  res_t                    res_r, res_nxt;

  logic                    slot_free;
  logic                    emit;
  res_t                    emit_res;

  logic signed [BND_W-1:0] val_ext;
  logic signed [BND_W-1:0] hi_sel;
  logic signed [BND_W-1:0] lo_sel;
  logic                    out_of_range;
  logic                    neg_in;
  logic [MAG_W-1:0]        mag_abs;
  logic [POS_W-1:0]        top_pos;
  logic                    at_min;

  logic [PROD_W-1:0]       prod;
  logic [MAG_W-1:0]        quot;
  logic [MAG_W-1:0]        tens;
  logic [DIGIT_W-1:0]      digit;
  logic [PATTERN_W-1:0]    digit_pat;

  // The output register can take a new result when it is empty or draining.
  assign slot_free = !out_valid_r || out_chan.ready;

  // Range check and magnitude of the held value, used in the check cycle.
  assign val_ext      = {{(BND_W - VALUE_W){val_r[VALUE_W-1]}}, val_r};
  assign hi_sel       = large_r ? L_HI : S_HI;
  assign lo_sel       = large_r ? L_LO : S_LO;
  assign out_of_range = (val_ext > hi_sel) || (val_ext < lo_sel);
  assign neg_in       = val_r[VALUE_W-1];
  assign mag_abs      = neg_in ? MAG_W'((~val_r) + VALUE_W'(1)) : MAG_W'(val_r);
  assign top_pos      = large_r ? POS_W'(LARGE_DIGITS - 1) : POS_W'(SMALL_DIGITS - 1);

  // Negative values leave position 0 for the sign, so digits stop at 1.
  assign at_min = (pos_r == POS_W'(neg_r));

  // Shared divide-by-ten unit: reciprocal multiply, then the remainder by
  // subtracting 8q + 2q. The quotient stays below 2**22, so tens cannot wrap.
  assign prod      = PROD_W'(mag_r) * PROD_W'(RECIP);
  assign quot      = MAG_W'(prod >> RECIP_SH);
  assign tens      = (quot << 3) + (quot << 1);
  assign digit     = DIGIT_W'(mag_r - tens);
  assign digit_pat = large_r ? alnum_pattern(digit) : seg7_pattern(digit);

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    large_nxt     = large_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    pos_nxt       = pos_r;
    sign_pend_nxt = sign_pend_r;
    emit          = 1'b0;
    emit_res      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          val_nxt   = in_chan.value;
          large_nxt = in_chan.target_large;
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (slot_free) begin
          if (out_of_range) begin
            emit           = 1'b1;
            emit_res.error = 1'b1;
            emit_res.last  = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            mag_nxt       = mag_abs;
            neg_nxt       = neg_in;
            pos_nxt       = top_pos;
            sign_pend_nxt = large_r;
            // The small display shows its minus sign as a digit at position 0.
            if (neg_in && !large_r) begin
              emit                 = 1'b1;
              emit_res.pattern     = MINUS_PATTERN;
              emit_res.digit_valid = 1'b1;
            end
            state_nxt = ST_DIGIT;
          end
        end
      end

      ST_DIGIT: begin
        if (slot_free) begin
          emit                   = 1'b1;
          emit_res.digit_pos     = DPOS_W'(pos_r);
          emit_res.pattern       = digit_pat;
          emit_res.digit_valid   = 1'b1;
          emit_res.sign_write    = sign_pend_r;
          emit_res.sign_negative = sign_pend_r && neg_r;
          emit_res.last          = at_min;
          sign_pend_nxt          = 1'b0;
          if (at_min) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt   = pos_r - POS_W'(1);
            mag_nxt   = quot;
            state_nxt = (quot == '0) ? ST_BLANK : ST_DIGIT;
          end
        end
      end

      ST_BLANK: begin
        if (slot_free) begin
          emit                 = 1'b1;
          emit_res.digit_pos   = DPOS_W'(pos_r);
          emit_res.digit_valid = 1'b1;
          emit_res.last        = at_min;
          if (at_min) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r - POS_W'(1);
          end
        end
      end
    endcase
  end

  // Output register: loads on every emitted result, empties when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = emit_res;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Work and payload registers need no reset.
  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    large_r     <= large_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    pos_r       <= pos_nxt;
    sign_pend_r <= sign_pend_nxt;
    res_r       <= res_nxt;
  end

  assign in_chan.ready          = (state_r == ST_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.digit_pos     = res_r.digit_pos;
  assign out_chan.pattern       = res_r.pattern;
  assign out_chan.digit_valid   = res_r.digit_valid;
  assign out_chan.sign_write    = res_r.sign_write;
  assign out_chan.sign_negative = res_r.sign_negative;
  assign out_chan.error         = res_r.error;
  assign out_chan.last          = res_r.last;

  // The position never walks past the sign slot while digits are produced.
  `SDSF_ASSERT_IMPLY(a_pos_floor, clk, rst_n,
                     (state_r == ST_DIGIT) || (state_r == ST_BLANK), pos_r >= POS_W'(neg_r))
  // Sign indicators are only driven for the large display.
  `SDSF_ASSERT_IMPLY(a_sign_large, clk, rst_n, emit && emit_res.sign_write, large_r)
  // An error result ends the item and writes nothing.
  `SDSF_ASSERT_IMPLY(a_err_alone, clk, rst_n, emit && emit_res.error,
                     emit_res.last && !emit_res.digit_valid && !emit_res.sign_write)
  // The final result of an item returns the sequencer to idle.
  `SDSF_ASSERT_NEXT(a_last_idle, clk, rst_n, emit && emit_res.last, state_r == ST_IDLE)

endmodule

// File: verif/signed_decimal_segment_formatter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_segment_formatter_core_tb
// Self-checking bench for the signed decimal segment formatter. Signed numbers
// go to both displays and every digit write, sign update and range error that
// comes back is checked against an independent digit-by-digit prediction.
// ----------------------------------------------------------------------------
module signed_decimal_segment_formatter_core_tb;
  import sdsf_pkg::*;

  localparam int SMALL_DIGITS = 4;
  localparam int LARGE_DIGITS = 7;
  localparam int RANDOM_NUMBERS = 400;
  // Longest busy stretch of one item (large display) plus some slack.
  localparam int DRAIN_CYCLES = LARGE_DIGITS + 10;
  localparam int STALL_CYCLES = 200;

  // One number offered to the block, with the display it is meant for.
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               to_large;
  } number_t;

  logic clk = 1'b0;
  logic rst_n;

  sdsf_in_if  in_chan ();
  sdsf_out_if out_chan ();

  signed_decimal_segment_formatter_core #(
    .SMALL_DIGITS(SMALL_DIGITS),
    .LARGE_DIGITS(LARGE_DIGITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Numbers still to be offered, and the digit writes predicted for the
  // numbers already accepted, oldest first.
  number_t queued_numbers[$];
  res_t    expected_writes[$];

  int numbers_sent   = 0;
  int small_numbers  = 0;
  int large_numbers  = 0;
  int range_errors   = 0;
  int negative_shown = 0;
  int writes_checked = 0;
  int mismatch_count = 0;

  // Raised by the pressure process to hold the result side off.
  logic hold_results = 1'b0;

  // 10 to the power n.
  function automatic longint decade(input int n);
    longint r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  // Segment glyph of one decimal digit. The alphanumeric display lights its
  // second middle segment (bit 10) wherever the seven-segment glyph uses G.
  function automatic logic [PATTERN_W-1:0] glyph_of(input int digit, input bit alnum);
    logic [PATTERN_W-1:0] seg;
    case (digit)
      0:       seg = 16'h003F;
      1:       seg = 16'h0006;
      2:       seg = 16'h005B;
      3:       seg = 16'h004F;
      4:       seg = 16'h0066;
      5:       seg = 16'h006D;
      6:       seg = 16'h007D;
      7:       seg = 16'h0007;
      8:       seg = 16'h007F;
      default: seg = 16'h006F;
    endcase
    if (alnum && seg[6]) begin
      seg[10] = 1'b1;
    end
    return seg;
  endfunction

  function automatic res_t digit_write(input int pos, input logic [PATTERN_W-1:0] pat,
                                       input bit sign_upd, input bit sign_neg);
    res_t w;
    w = '0;
    w.digit_pos     = pos[DPOS_W-1:0];
    w.pattern       = pat;
    w.digit_valid   = 1'b1;
    w.sign_write    = sign_upd;
    w.sign_negative = sign_neg;
    return w;
  endfunction

  // Works out every write that one accepted number causes and queues them.
  // Digits go right to left until the magnitude runs out; the remaining
  // positions down to the sign position are then blanked.
  task automatic predict_display_writes(input logic signed [VALUE_W-1:0] raw,
                                        input logic to_large);
    res_t   burst[$];
    res_t   w;
    longint v;
    longint hi;
    longint lo;
    longint mag;
    int     ndig;
    int     pos;
    int     lowest;
    bit     neg;
    bit     sign_pending;
    v    = raw;
    ndig = to_large ? LARGE_DIGITS : SMALL_DIGITS;
    hi   = decade(ndig) - 1;
    lo   = -(decade(ndig - 1) - 1);
    if (to_large) large_numbers++;
    else small_numbers++;
    if (v > hi || v < lo) begin
      // Out of range: a single error write and nothing on the display.
      w = '0;
      w.error = 1'b1;
      w.last  = 1'b1;
      expected_writes.push_back(w);
      range_errors++;
      return;
    end
    neg          = (v < 0);
    mag          = neg ? -v : v;
    lowest       = neg ? 1 : 0;
    pos          = ndig - 1;
    sign_pending = to_large;
    if (neg) negative_shown++;
    // The small display has no sign indicators, so a minus glyph goes first.
    if (neg && !to_large) begin
      burst.push_back(digit_write(0, MINUS_PATTERN, 1'b0, 1'b0));
    end
    while (pos >= lowest) begin
      burst.push_back(digit_write(pos, glyph_of(int'(mag % 10), to_large),
                                  sign_pending, sign_pending && neg));
      sign_pending = 1'b0;
      pos--;
      mag = mag / 10;
      if (mag == 0) break;
    end
    while (pos >= lowest) begin
      burst.push_back(digit_write(pos, '0, 1'b0, 1'b0));
      pos--;
    end
    burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) expected_writes.push_back(burst[i]);
  endtask

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 60) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      note_mismatch($sformatf("write %0d field %s got 0x%0h expected 0x%0h",
                              writes_checked, name, got, want));
    end
  endtask

  task automatic add_number(input longint v, input bit to_large);
    number_t n;
    n.value    = v[VALUE_W-1:0];
    n.to_large = to_large;
    queued_numbers.push_back(n);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued numbers, holding each until the block takes it.
  // The prediction is made at the edge where the item is accepted. Outside a
  // steady window the sender holds back at random, about 28 times in a hundred.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : number_driver
    number_t next_number;
    bit      steady_source;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_display_writes(in_chan.value, in_chan.target_large);
        numbers_sent++;
      end
      steady_source = (numbers_sent >= 220 && numbers_sent < 300);
      if (!in_chan.valid || in_chan.ready) begin
        if (queued_numbers.size() != 0 && (steady_source || $urandom_range(99) >= 28)) begin
          next_number          = queued_numbers.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.value        <= next_number.value;
          in_chan.target_large <= next_number.to_large;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks every accepted write against the oldest prediction and
  // paces ready. A steady window keeps ready high; the pressure process can
  // force it low for a long stretch.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : write_monitor
    res_t got;
    res_t want;
    bit   steady_sink;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.digit_pos     = out_chan.digit_pos;
        got.pattern       = out_chan.pattern;
        got.digit_valid   = out_chan.digit_valid;
        got.sign_write    = out_chan.sign_write;
        got.sign_negative = out_chan.sign_negative;
        got.error         = out_chan.error;
        got.last          = out_chan.last;
        if (expected_writes.size() == 0) begin
          note_mismatch($sformatf("unexpected write pos %0d pattern 0x%0h error %0b",
                                  got.digit_pos, got.pattern, got.error));
        end else begin
          want = expected_writes.pop_front();
          check_field("digit_pos", got.digit_pos, want.digit_pos);
          check_field("pattern", got.pattern, want.pattern);
          check_field("digit_valid", got.digit_valid, want.digit_valid);
          check_field("sign_write", got.sign_write, want.sign_write);
          check_field("sign_negative", got.sign_negative, want.sign_negative);
          check_field("error", got.error, want.error);
          check_field("last", got.last, want.last);
        end
        writes_checked++;
      end
      steady_sink = (writes_checked >= 900 && writes_checked < 1400);
      out_chan.ready <= !hold_results && (steady_sink || $urandom_range(99) >= 28);
    end
  end

  // Pressure: once a hundred numbers are in, the result side holds off for a
  // long stretch while the driver keeps offering, so the block backs up.
  initial begin : result_backpressure
    wait (numbers_sent >= 100);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("signed_decimal_segment_formatter_core regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int     pick;
    int     ndig;
    int     len;
    int     total_numbers;
    bit     to_large;
    bit     neg;
    longint mag;
    longint v;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.value        = '0;
    in_chan.target_large = 1'b0;
    out_chan.ready       = 1'b0;

    // Directed part: zero, the range edges on both sides of both displays,
    // the field extremes, single digits, negatives and all ten glyphs.
    add_number(0, 1'b0);
    add_number(0, 1'b1);
    add_number(9999, 1'b0);
    add_number(10000, 1'b0);
    add_number(-999, 1'b0);
    add_number(-1000, 1'b0);
    add_number(-1, 1'b0);
    add_number(7, 1'b0);
    add_number(1234, 1'b0);
    add_number(-56, 1'b0);
    add_number(9999999, 1'b1);
    add_number(10000000, 1'b1);
    add_number(-999999, 1'b1);
    add_number(-1000000, 1'b1);
    add_number(-1, 1'b1);
    add_number(5, 1'b1);
    add_number(1234567, 1'b1);
    add_number(9876543, 1'b1);
    add_number(-234580, 1'b1);
    add_number(16777215, 1'b0);
    add_number(-16777216, 1'b1);
    add_number(16777215, 1'b1);
    add_number(-16777216, 1'b0);
    add_number(980, 1'b0);

    // Random part: mostly in-range numbers of random length and sign, some
    // numbers right at the range edges, and some raw 25-bit noise.
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      pick     = $urandom_range(99);
      to_large = $urandom_range(1);
      ndig     = to_large ? LARGE_DIGITS : SMALL_DIGITS;
      if (pick < 12) begin
        v = $signed(25'($urandom));
      end else if (pick < 20) begin
        case ($urandom_range(3))
          0:       v = decade(ndig) - 1;
          1:       v = decade(ndig);
          2:       v = -(decade(ndig - 1) - 1);
          default: v = -decade(ndig - 1);
        endcase
      end else begin
        len = $urandom_range(ndig, 1);
        neg = (len < ndig) && ($urandom_range(2) == 0);
        if (len == 1) mag = $urandom_range(9, 0);
        else mag = $urandom_range(int'(decade(len) - 1), int'(decade(len - 1)));
        v = neg ? -mag : mag;
      end
      add_number(v, to_large);
    end
    total_numbers = queued_numbers.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Every number must be accepted and every predicted write seen.
    while (numbers_sent < total_numbers || expected_writes.size() != 0) @(posedge clk);
    // Any stray write after the last expected one is caught here.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d numbers (%0d small display, %0d large display), %0d negative",
             numbers_sent, small_numbers, large_numbers, negative_shown);
    $display("on screen and %0d out of range; %0d writes checked, %0d mismatches.",
             range_errors, writes_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("signed_decimal_segment_formatter_core regression: pass");
    end else begin
      $display("signed_decimal_segment_formatter_core regression: fail");
    end
    $finish;
  end

endmodule
